/* hw/rtl/mcs_pkg.sv */
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared types and constants of the mailbox command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned CodeW     = 16;
  localparam int unsigned DataW     = 64;
  localparam int unsigned KindW     = 2;
  localparam int unsigned TargetW   = 32;
  localparam int unsigned AddrW     = 40;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned ResultW   = 8;
  localparam int unsigned PollW     = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 40;

  localparam logic [15:0]      MagicWord     = 16'hab10;
  localparam logic [AddrW-1:0] CmdOffset     = AddrW'(8'h08);
  localparam logic [PollW-1:0] PollLimitRst  = PollW'(30 * 10);

  typedef enum logic [CmdW-1:0] {
    CMD_START  = 2'd0,
    CMD_RESP   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_IRQ    = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_READ     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_COMPLETE = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE        = 3'd0,
    ST_NO_DEVICE   = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_BUSY        = 3'd3,
    ST_INTERRUPTED = 3'd4,
    ST_TIMEOUT     = 3'd5,
    ST_BUS_ERROR   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RD_STATUS = 3'd1,
    PH_WR_CMD    = 3'd2,
    PH_RD_START  = 3'd3,
    PH_TK_START  = 3'd4,
    PH_RD_BUSY   = 3'd5,
    PH_TK_BUSY   = 3'd6
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_ID  = 2'd0,
    REG_BASE_ADDR  = 2'd1,
    REG_POLL_LIMIT = 2'd2
  } reg_idx_e;

endpackage

`default_nettype wire

/* hw/rtl/mcs_if.sv */
// ----------------------------------------------------------------------------
// mcs_in_if / mcs_out_if
// Valid/ready channels of the mailbox command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcs_in_if import mcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [CodeW-1:0] code;
  logic [DataW-1:0] read_data;
  logic             bus_error;

  modport source (output valid, cmd, code, read_data, bus_error, input ready);
  modport sink   (input valid, cmd, code, read_data, bus_error, output ready);
endinterface

interface mcs_out_if import mcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [TargetW-1:0] bus_target;
  logic [AddrW-1:0]   bus_address;
  logic [DataW-1:0]   write_data;
  logic [StatusW-1:0] status;
  logic [ResultW-1:0] result_code;

  modport source (output valid, kind, bus_target, bus_address, write_data, status,
                  result_code, input ready);
  modport sink   (input valid, kind, bus_target, bus_address, write_data, status,
                  result_code, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mailbox_command_sequencer_core.sv */
// ----------------------------------------------------------------------------
// mailbox_command_sequencer_core
// Requester side of a service-processor command mailbox.
// ----------------------------------------------------------------------------
// Each transfer on the input channel (start, bus response, poll tick or
// interrupt) is handled in the cycle it is accepted and produces at most one
// transfer on the output channel: a bus read, a bus write or a completion with
// its status. The block takes one input transfer per clock; the only stall
// comes from the single output register, which holds a result until the sink
// takes it, and a new input is accepted in the same cycle the old result
// leaves. Results appear in the cycle after the input that caused them.
`default_nettype none

module mailbox_command_sequencer_core import mcs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  mcs_in_if.sink                   in_s,
  mcs_out_if.source                out_s
);

  // configuration
  logic [TargetW-1:0] target_id_q;
  logic [AddrW-1:0]   base_addr_q;
  logic [PollW-1:0]   poll_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_id_q  <= '0;
      base_addr_q  <= '0;
      poll_limit_q <= PollLimitRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TARGET_ID:  target_id_q  <= cfg_wdata_i[TargetW-1:0];
        REG_BASE_ADDR:  base_addr_q  <= cfg_wdata_i[AddrW-1:0];
        REG_POLL_LIMIT: poll_limit_q <= cfg_wdata_i[PollW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_e            phase_q, phase_d;
  logic [CodeW-1:0]  held_code_q, held_code_d;
  logic [PollW-1:0]  polls_left_q, polls_left_d;

  logic     out_valid_q;
  logic     in_accept;
  cmd_e     cmd;
  logic     rd_bit0;
  logic     magic_ok;
  logic     version_ok;
  logic     awaiting_resp;
  logic     budget_empty;

  assign in_s.ready    = !out_valid_q || out_s.ready;
  assign in_accept     = in_s.valid && in_s.ready;
  assign cmd           = cmd_e'(in_s.cmd);
  assign rd_bit0       = in_s.read_data[0];
  assign magic_ok      = in_s.read_data[63:48] == MagicWord;
  assign version_ok    = (in_s.read_data[43:40] == held_code_q[15:12]) &&
                         (in_s.read_data[43:32] >= held_code_q[11:0]);
  assign awaiting_resp = (phase_q == PH_RD_STATUS) || (phase_q == PH_WR_CMD) ||
                         (phase_q == PH_RD_START)  || (phase_q == PH_RD_BUSY);
  assign budget_empty  = polls_left_q == '0;

  // next state
  always_comb begin
    phase_d      = phase_q;
    held_code_d  = held_code_q;
    polls_left_d = polls_left_q;
    if (in_accept) begin
      case (cmd)
        CMD_START: begin
          if (phase_q == PH_IDLE) begin
            held_code_d  = in_s.code;
            polls_left_d = poll_limit_q;
            phase_d      = PH_RD_STATUS;
          end
        end
        CMD_RESP: begin
          if (awaiting_resp) begin
            if (in_s.bus_error) begin
              phase_d = PH_IDLE;
            end else begin
              unique case (phase_q)
                PH_RD_STATUS: begin
                  phase_d = (magic_ok && version_ok && !rd_bit0) ? PH_WR_CMD : PH_IDLE;
                end
                PH_WR_CMD, PH_RD_START: begin
                  if (phase_q == PH_RD_START && rd_bit0) begin
                    phase_d = PH_TK_START;
                  end else if (budget_empty) begin
                    phase_d = PH_IDLE;
                  end else begin
                    polls_left_d = polls_left_q - 1'b1;
                    phase_d      = (phase_q == PH_WR_CMD) ? PH_RD_START : PH_RD_BUSY;
                  end
                end
                PH_RD_BUSY: begin
                  phase_d = rd_bit0 ? PH_TK_BUSY : PH_IDLE;
                end
                default: ;
              endcase
            end
          end
        end
        CMD_TICK: begin
          if (phase_q == PH_TK_START || phase_q == PH_TK_BUSY) begin
            if (budget_empty) begin
              phase_d = PH_IDLE;
            end else begin
              polls_left_d = polls_left_q - 1'b1;
              phase_d      = (phase_q == PH_TK_START) ? PH_RD_START : PH_RD_BUSY;
            end
          end
        end
        default: begin
          if (phase_q == PH_TK_START || phase_q == PH_TK_BUSY) begin
            phase_d = PH_IDLE;
          end
        end
      endcase
    end
  end

  // result of the current transfer
  logic           emit;
  kind_e          kind_d;
  logic           cmd_word;
  status_e        status_d;
  logic [7:0]     result_d;

  always_comb begin
    emit     = 1'b0;
    kind_d   = KIND_READ;
    cmd_word = 1'b0;
    status_d = ST_DONE;
    result_d = '0;
    case (cmd)
      CMD_START: begin
        emit = phase_q == PH_IDLE;
      end
      CMD_RESP: begin
        if (awaiting_resp) begin
          if (in_s.bus_error) begin
            emit     = 1'b1;
            kind_d   = KIND_COMPLETE;
            status_d = ST_BUS_ERROR;
          end else begin
            unique case (phase_q)
              PH_RD_STATUS: begin
                emit = 1'b1;
                if (!magic_ok) begin
                  kind_d   = KIND_COMPLETE;
                  status_d = ST_NO_DEVICE;
                end else if (!version_ok) begin
                  kind_d   = KIND_COMPLETE;
                  status_d = ST_UNSUPPORTED;
                end else if (rd_bit0) begin
                  kind_d   = KIND_COMPLETE;
                  status_d = ST_BUSY;
                end else begin
                  kind_d   = KIND_WRITE;
                  cmd_word = 1'b1;
                end
              end
              PH_WR_CMD, PH_RD_START: begin
                if (!(phase_q == PH_RD_START && rd_bit0)) begin
                  emit     = 1'b1;
                  cmd_word = phase_q == PH_WR_CMD;
                  if (budget_empty) begin
                    kind_d   = KIND_COMPLETE;
                    status_d = ST_TIMEOUT;
                  end
                end
              end
              PH_RD_BUSY: begin
                if (!rd_bit0) begin
                  emit     = 1'b1;
                  kind_d   = KIND_COMPLETE;
                  result_d = in_s.read_data[15:8];
                end
              end
              default: ;
            endcase
          end
        end
      end
      CMD_TICK: begin
        if (phase_q == PH_TK_START || phase_q == PH_TK_BUSY) begin
          emit     = 1'b1;
          cmd_word = phase_q == PH_TK_START;
          if (budget_empty) begin
            kind_d   = KIND_COMPLETE;
            status_d = ST_TIMEOUT;
          end
        end
      end
      default: begin
        if (phase_q == PH_TK_START || phase_q == PH_TK_BUSY) begin
          emit     = 1'b1;
          kind_d   = KIND_COMPLETE;
          status_d = ST_INTERRUPTED;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      held_code_q  <= '0;
      polls_left_q <= '0;
    end else begin
      phase_q      <= phase_d;
      held_code_q  <= held_code_d;
      polls_left_q <= polls_left_d;
    end
  end

  // output register
  kind_e              kind_q;
  logic [TargetW-1:0] target_q;
  logic [AddrW-1:0]   addr_q;
  logic [DataW-1:0]   wdata_q;
  status_e            status_q;
  logic [ResultW-1:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_s.ready) begin
      out_valid_q <= in_accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      kind_q   <= kind_d;
      status_q <= status_d;
      result_q <= result_d;
      if (kind_d == KIND_COMPLETE) begin
        target_q <= '0;
        addr_q   <= '0;
        wdata_q  <= '0;
      end else begin
        target_q <= target_id_q;
        addr_q   <= base_addr_q + (cmd_word ? CmdOffset : '0);
        wdata_q  <= (kind_d == KIND_WRITE) ?
                    {{(DataW-CodeW-16){1'b0}}, held_code_q, 15'd0, 1'b1} : '0;
      end
    end
  end

  assign out_s.valid       = out_valid_q;
  assign out_s.kind        = kind_q;
  assign out_s.bus_target  = target_q;
  assign out_s.bus_address = addr_q;
  assign out_s.write_data  = wdata_q;
  assign out_s.status      = status_q;
  assign out_s.result_code = result_q;

  // checks
  logic start_taken;
  assign start_taken = in_accept && cmd == CMD_START && phase_q == PH_IDLE;

  a_complete_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && emit && kind_d == KIND_COMPLETE |=> phase_q == PH_IDLE)
    else $error("completion did not return to idle");

  a_start_busy_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && cmd == CMD_START && phase_q != PH_IDLE |=>
      phase_q == $past(phase_q) && $stable(held_code_q))
    else $error("start disturbed a running command");

  a_budget_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_taken |=> polls_left_q <= $past(polls_left_q))
    else $error("poll budget grew without a start");

  a_result_needs_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> !$rose(out_valid_q))
    else $error("result appeared without an input transfer");

endmodule

`default_nettype wire
